// File: rtl/core/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants for the bilinear image sampler
// Holds the item modes, the register map and the width constants.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int CoordW = 20;
  localparam int ValW   = 16;
  localparam int WgtW   = 17;  // weights reach 1.0 = 65536

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_ALL    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CHANS  = 2'd2,
    REG_WRAP   = 2'd3
  } reg_idx_t;

endpackage

// File: rtl/core/bis_axis.sv
// ----------------------------------------------------------------------------
// bis_axis: per-axis coordinate setup
// Scales a Q4.16 coordinate by the image size, splits floor and fraction,
// and gives neighbour indices and weights. Registered output, loaded when
// a sample is taken.
// ----------------------------------------------------------------------------
module bis_axis #(
  parameter int MaxN = 64,
  localparam int IdxW = $clog2(MaxN),
  localparam int NW = $clog2(MaxN + 1)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [bis_pkg::CoordW-1:0] coord,
  input  logic [NW-1:0]                n,
  input  logic                         wrap,
  output logic [IdxW-1:0]              lo_r,
  output logic [IdxW-1:0]              hi_r,
  output logic [bis_pkg::WgtW-1:0]     wlo_r,
  output logic [bis_pkg::WgtW-1:0]     whi_r
);
  import bis_pkg::*;

  localparam int PW = CoordW + NW + 1;
  localparam int IW = PW - 16;

  logic signed [PW-1:0] prod;
  logic signed [IW-1:0] idx;
  logic [15:0]          frac;
  logic [IdxW-1:0]      m;
  logic [IdxW-1:0]      lo_nxt, hi_nxt;
  logic                 out_nxt;

  // scale and split; arithmetic shift is floor
  assign prod = PW'(coord) * $signed({1'b0, n});
  assign idx  = prod[PW-1:16];
  assign frac = prod[15:0];

  // wrap: index lies within [-8n, 8n), so reduce bit by bit
  always_comb begin
    logic signed [IW:0] t;
    t = IW'(idx);
    for (int k = 4; k >= 0; k--) begin
      if (t < 0) t = t + ((IW+1)'(n) <<< k);
      else if (t >= ((IW+1)'(n) <<< k)) t = t - ((IW+1)'(n) <<< k);
    end
    if (t < 0) t = t + (IW+1)'(n);
    m = t[IdxW-1:0];
  end

  always_comb begin
    out_nxt = 1'b0;
    if (wrap) begin
      lo_nxt = m;
      hi_nxt = (NW'(m) + NW'(1) >= n) ? '0 : m + IdxW'(1);
    end else begin
      out_nxt = (idx < 0) || (idx >= IW'(n));
      lo_nxt  = idx[IdxW-1:0];
      hi_nxt  = (NW'(lo_nxt) + NW'(1) >= n) ? lo_nxt : lo_nxt + IdxW'(1);
      if (out_nxt) begin
        lo_nxt = '0;
        hi_nxt = '0;
      end
    end
  end

  // hold setup results for the read stage until the next sample
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      wlo_r <= out_nxt ? '0 : WgtW'(17'h10000 - {1'b0, frac});
      whi_r <= out_nxt ? '0 : {1'b0, frac};
    end
  end
endmodule

// File: rtl/core/bis_front.sv
// ----------------------------------------------------------------------------
// bis_front: input side
// Takes items, clamps the sizes, writes pixels, and sets up sample ops,
// one per channel for an all-channel sample, else one, onto the op stream.
// ----------------------------------------------------------------------------
module bis_front #(
  parameter int MaxW = 64,
  parameter int MaxH = 64,
  parameter int MaxC = 4,
  localparam int XW = $clog2(MaxW),
  localparam int YW = $clog2(MaxH),
  localparam int CW = (MaxC > 1) ? $clog2(MaxC) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        mode,
  input  logic signed [bis_pkg::CoordW-1:0] sample_x,
  input  logic signed [bis_pkg::CoordW-1:0] sample_y,
  input  logic [1:0]                        channel,
  input  logic [5:0]                        write_col,
  input  logic [5:0]                        write_row,
  input  logic [bis_pkg::ValW-1:0]          write_value,
  input  logic [6:0]                        img_w,
  input  logic [6:0]                        img_h,
  input  logic [2:0]                        chans,
  input  logic                              wrap,
  // write port into the back's store
  output logic                              wr_en,
  output logic [XW+YW+CW-1:0]               wr_addr,
  output logic [bis_pkg::ValW-1:0]          wr_data,
  // op stream toward the back
  output logic                              op_valid,
  input  logic                              op_ready,
  output logic [XW-1:0]                     x0,
  output logic [XW-1:0]                     x1,
  output logic [YW-1:0]                     y0,
  output logic [YW-1:0]                     y1,
  output logic [bis_pkg::WgtW-1:0]          wx0,
  output logic [bis_pkg::WgtW-1:0]          wx1,
  output logic [bis_pkg::WgtW-1:0]          wy0,
  output logic [bis_pkg::WgtW-1:0]          wy1,
  output logic [3:0]                        op_ch,
  output logic                              op_zero,
  output logic                              op_last
);
  import bis_pkg::*;

  localparam int WN = $clog2(MaxW + 1);
  localparam int HN = $clog2(MaxH + 1);

  logic [WN-1:0] w_eff;
  logic [HN-1:0] h_eff;
  logic [3:0]    c_eff;
  logic          acc;
  logic          ld;

  // clamp the size registers
  always_comb begin
    w_eff = (img_w == 7'd0) ? WN'(1) : ((32'(img_w) > MaxW) ? WN'(MaxW) : WN'(img_w));
    h_eff = (img_h == 7'd0) ? HN'(1) : ((32'(img_h) > MaxH) ? HN'(MaxH) : HN'(img_h));
    c_eff = (chans == 3'd0) ? 4'd1 : ((32'(chans) > MaxC) ? 4'(MaxC) : {1'b0, chans});
  end

  // stage 1 holds one expanding sample
  logic       s1_v_r;
  logic [3:0] s1_ch_r, s1_end_r, s1_nch_r;
  logic [XW-1:0] x0_w, x1_w;
  logic [YW-1:0] y0_w, y1_w;

  assign full = s1_v_r && !(op_ready && (s1_ch_r + 4'd1 == s1_end_r));
  assign acc  = push && !full;
  assign ld   = acc && (mode == MODE_SAMPLE || mode == MODE_ALL);

  bis_axis #(.MaxN(MaxW)) u_ax (
    .clk, .en(ld), .coord(sample_x), .n(w_eff), .wrap,
    .lo_r(x0_w), .hi_r(x1_w), .wlo_r(wx0), .whi_r(wx1));
  bis_axis #(.MaxN(MaxH)) u_ay (
    .clk, .en(ld), .coord(sample_y), .n(h_eff), .wrap,
    .lo_r(y0_w), .hi_r(y1_w), .wlo_r(wy0), .whi_r(wy1));

  assign x0 = x0_w;
  assign x1 = x1_w;
  assign y0 = y0_w;
  assign y1 = y1_w;

  // pixel writes go straight to the store
  always_comb begin
    wr_en   = acc && (mode == MODE_WRITE) && (32'(write_col) < MaxW)
              && (32'(write_row) < MaxH) && (32'(channel) < MaxC);
    wr_addr = {YW'(write_row), XW'(write_col), CW'(channel)};
    wr_data = write_value;
  end

  // load a new sample, else advance the channel counter per op beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ld) begin
      s1_v_r   <= 1'b1;
      s1_ch_r  <= (mode == MODE_SAMPLE) ? {2'b0, channel} : 4'd0;
      s1_end_r <= (mode == MODE_SAMPLE) ? {2'b0, channel} + 4'd1 : c_eff;
      s1_nch_r <= c_eff;
    end else if (s1_v_r && op_ready) begin
      s1_ch_r <= s1_ch_r + 4'd1;
      if (s1_ch_r + 4'd1 == s1_end_r) s1_v_r <= 1'b0;
    end
  end

  assign op_valid = s1_v_r;
  assign op_ch    = s1_ch_r;
  assign op_zero  = s1_ch_r >= s1_nch_r;
  assign op_last  = s1_ch_r + 4'd1 == s1_end_r;
endmodule

// File: rtl/core/bis_back.sv
// ----------------------------------------------------------------------------
// bis_back: pixel store and blend pipeline
// Two copies of the pixel store, each read at two addresses, give the four
// neighbours together; weights multiply, terms sum, results queue.
// ----------------------------------------------------------------------------
module bis_back #(
  parameter int MaxW = 64,
  parameter int MaxH = 64,
  parameter int MaxC = 4,
  localparam int XW = $clog2(MaxW),
  localparam int YW = $clog2(MaxH),
  localparam int CW = (MaxC > 1) ? $clog2(MaxC) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [XW+YW+CW-1:0]      wr_addr,
  input  logic [bis_pkg::ValW-1:0] wr_data,
  input  logic                     op_valid,
  output logic                     op_ready,
  input  logic [XW-1:0]            x0,
  input  logic [XW-1:0]            x1,
  input  logic [YW-1:0]            y0,
  input  logic [YW-1:0]            y1,
  input  logic [bis_pkg::WgtW-1:0] wx0,
  input  logic [bis_pkg::WgtW-1:0] wx1,
  input  logic [bis_pkg::WgtW-1:0] wy0,
  input  logic [bis_pkg::WgtW-1:0] wy1,
  input  logic [3:0]               op_ch,
  input  logic                     op_zero,
  input  logic                     op_last,
  output logic                     empty,
  input  logic                     pop,
  output logic [bis_pkg::ValW-1:0] out_value,
  output logic [1:0]               out_ch,
  output logic                     out_last
);
  import bis_pkg::*;

  localparam int AW = XW + YW + CW;
  localparam int Depth = 1 << AW;
  localparam int QD = 8;

  // copy a serves the lower row, copy b the upper row
  logic [ValW-1:0] store_a [Depth];
  logic [ValW-1:0] store_b [Depth];

  // queue bookkeeping; a beat enters only if a slot is free for its result
  logic [3:0] cnt_r, cnt_nxt, inflight;
  logic       v1_r, v2_r, v3_r;
  logic       go;
  assign inflight = 4'(v1_r) + 4'(v2_r) + 4'(v3_r);
  assign op_ready = (cnt_r + inflight) < 4'(QD);
  assign go = op_valid && op_ready;

  logic [CW-1:0] cc;
  assign cc = CW'(op_ch);

  // write both copies; read the four neighbours
  logic [ValW-1:0] rd0_r, rd1_r, rd2_r, rd3_r;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_a[wr_addr] <= wr_data;
      store_b[wr_addr] <= wr_data;
    end
    rd0_r <= store_a[{y0, x0, cc}];
    rd1_r <= store_a[{y0, x1, cc}];
    rd2_r <= store_b[{y1, x0, cc}];
    rd3_r <= store_b[{y1, x1, cc}];
  end

  // stage 1: corner weights
  logic [WgtW-1:0] w00_r, w10_r, w01_r, w11_r;
  logic            z1_r, l1_r, z2_r, l2_r, l3_r;
  logic [1:0]      c1_r, c2_r, c3_r;
  logic [32:0]     p00, p10, p01, p11;
  assign p00 = wx0 * wy0;
  assign p10 = wx1 * wy0;
  assign p01 = wx0 * wy1;
  assign p11 = wx1 * wy1;
  always_ff @(posedge clk) begin
    w00_r <= p00[32:16];
    w10_r <= p10[32:16];
    w01_r <= p01[32:16];
    w11_r <= p11[32:16];
    z1_r <= op_zero;
    l1_r <= op_last;
    c1_r <= op_ch[1:0];
  end

  // stage 2: pixel terms
  logic [ValW-1:0] t00_r, t10_r, t01_r, t11_r;
  logic [31:0]     m00, m10, m01, m11;
  assign m00 = rd0_r * w00_r;
  assign m10 = rd1_r * w10_r;
  assign m01 = rd2_r * w01_r;
  assign m11 = rd3_r * w11_r;
  always_ff @(posedge clk) begin
    t00_r <= m00[31:16];
    t10_r <= m10[31:16];
    t01_r <= m01[31:16];
    t11_r <= m11[31:16];
    z2_r <= z1_r;
    l2_r <= l1_r;
    c2_r <= c1_r;
  end

  // stage 3: sum with saturation, or zero for a channel past the count
  logic [17:0]     sum;
  logic [ValW-1:0] s3_r;
  assign sum = 18'(t00_r) + 18'(t10_r) + 18'(t01_r) + 18'(t11_r);
  always_ff @(posedge clk) begin
    s3_r <= z2_r ? '0 : (sum > 18'hFFFF ? 16'hFFFF : sum[15:0]);
    l3_r <= l2_r;
    c3_r <= c2_r;
  end

  // result queue
  logic [ValW+2:0] q_mem [QD];
  logic [2:0]      wp_r, rp_r;
  logic            deq;
  assign empty = (cnt_r == 4'd0);
  assign deq = pop && !empty;
  assign {out_value, out_ch, out_last} = q_mem[rp_r];
  always_comb cnt_nxt = cnt_r + 4'(v3_r) - 4'(deq);

  always_ff @(posedge clk) begin
    if (v3_r) q_mem[wp_r] <= {s3_r, c3_r, l3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      cnt_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
      cnt_r <= cnt_nxt;
      if (v3_r) wp_r <= wp_r + 3'd1;
      if (deq) rp_r <= rp_r + 3'd1;
    end
  end
endmodule

// File: rtl/core/bilinear_image_sampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_image_sampler_top: bilinear sampler over a duplicated pixel store
//   channel  | handshake        | contents
//   in_      | push / full      | write or sample item
//   out_     | pop / empty      | one channel result, last marks the end
//   cfg_     | APB write/read   | size, channel count, wrap mode
// One op beat per cycle while the back has room: one per one-channel sample,
// none per write, one per channel in use per all-channel sample (op expansion
// counter). Results pass setup, weight, term and sum registers to the queue.
// Reset clears control only; the store is undefined until written.
// A result queue with no free slot, results in flight counted, stalls the op
// stream; a held sample then stalls the input, writes included.
// ----------------------------------------------------------------------------
module bilinear_image_sampler_top #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic signed [19:0] in_sample_x,
  input  logic signed [19:0] in_sample_y,
  input  logic [1:0]  in_channel,
  input  logic [5:0]  in_write_col,
  input  logic [5:0]  in_write_row,
  input  logic [15:0] in_write_value,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_sample_value,
  output logic [1:0]  out_result_channel,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bis_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [6:0] w_r, h_r;
  logic [2:0] c_r;
  logic       wrap_r;
  reg_idx_t   ridx;

  // register file
  assign pready = 1'b1;
  assign ridx = reg_idx_t'(paddr[3:2]);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 7'd64;
      h_r <= 7'd64;
      c_r <= 3'd4;
      wrap_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_WIDTH:  w_r <= pwdata[6:0];
        REG_HEIGHT: h_r <= pwdata[6:0];
        REG_CHANS:  c_r <= pwdata[2:0];
        REG_WRAP:   wrap_r <= pwdata[0];
        default:    ;
      endcase
    end
  end
  always_comb begin
    case (ridx)
      REG_WIDTH:  prdata = {25'd0, w_r};
      REG_HEIGHT: prdata = {25'd0, h_r};
      REG_CHANS:  prdata = {29'd0, c_r};
      REG_WRAP:   prdata = {31'd0, wrap_r};
      default:    prdata = '0;
    endcase
  end

  logic                 wr_en, op_valid, op_ready, op_zero, op_last;
  logic [XW+YW+CW-1:0]  wr_addr;
  logic [15:0]          wr_data;
  logic [XW-1:0]        x0, x1;
  logic [YW-1:0]        y0, y1;
  logic [WgtW-1:0]      wx0, wx1, wy0, wy1;
  logic [3:0]           op_ch;

  bis_front #(.MaxW(MAX_WIDTH), .MaxH(MAX_HEIGHT), .MaxC(MAX_CHANNELS)) u_front (
    .clk, .rst_n, .push, .full,
    .mode(in_mode), .sample_x(in_sample_x), .sample_y(in_sample_y),
    .channel(in_channel), .write_col(in_write_col), .write_row(in_write_row),
    .write_value(in_write_value),
    .img_w(w_r), .img_h(h_r), .chans(c_r), .wrap(wrap_r),
    .wr_en, .wr_addr, .wr_data,
    .op_valid, .op_ready, .x0, .x1, .y0, .y1, .wx0, .wx1, .wy0, .wy1,
    .op_ch, .op_zero, .op_last);

  bis_back #(.MaxW(MAX_WIDTH), .MaxH(MAX_HEIGHT), .MaxC(MAX_CHANNELS)) u_back (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data,
    .op_valid, .op_ready, .x0, .x1, .y0, .y1, .wx0, .wx1, .wy0, .wy1,
    .op_ch, .op_zero, .op_last,
    .empty, .pop, .out_value(out_sample_value), .out_ch(out_result_channel),
    .out_last);

  // an op beat only moves when the back has room
  a_op_room: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && op_ready) |-> ((u_back.cnt_r + u_back.inflight) < 4'd8))
    else $error("op accepted without queue room");

  // the queue count never exceeds its depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    u_back.cnt_r <= 4'd8) else $error("result queue overflow");

  // a held expansion keeps the input stalled until its last op moves
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && !op_ready) |-> full) else $error("input taken mid expansion");
endmodule
